// ===== rtl/bcr_pkg.sv =====
`timescale 1ns / 1ps
package bcr_pkg;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_CORNER_A_X  = 3'd0;
  localparam logic [2:0] REG_CORNER_A_Y  = 3'd1;
  localparam logic [2:0] REG_CORNER_B_X  = 3'd2;
  localparam logic [2:0] REG_CORNER_B_Y  = 3'd3;
  localparam logic [2:0] REG_RESTITUTION = 3'd4;
  localparam logic [2:0] REG_STEP_TIME   = 3'd5;

  localparam int unsigned ADDR_W = 5;

  // Reset values
  localparam logic [17:0] RESTITUTION_RST = 18'd65536;  // 1.0 in Q2.16
  localparam logic [17:0] RESTITUTION_ONE = 18'd65536;

  typedef enum logic [1:0] {
    SIDE_LEFT   = 2'd0,
    SIDE_TOP    = 2'd1,
    SIDE_RIGHT  = 2'd2,
    SIDE_BOTTOM = 2'd3
  } side_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic        [30:0] radius;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               hit;
  } out_item_t;

  // Classified particle handed from front to back
  typedef struct packed {
    logic               hit;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [32:0] vel_x;  // after optional negation
    logic signed [32:0] vel_y;
  } mid_item_t;

  typedef struct packed {
    logic signed [31:0] corner_a_x;
    logic signed [31:0] corner_a_y;
    logic signed [31:0] corner_b_x;
    logic signed [31:0] corner_b_y;
    logic        [17:0] restitution;
    logic        [31:0] step_time;
  } cfg_t;

  // Saturate a signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] res;
    if (v > 49'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -49'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/bcr_fifo.sv =====
`timescale 1ns / 1ps
module bcr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("fifo occupancy above depth");

  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("fifo occupancy did not grow on push");
`endif

endmodule

// ===== rtl/bcr_front.sv =====
`timescale 1ns / 1ps
module bcr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  bcr_pkg::cfg_t       cfg,
  input  logic                in_vld,
  output logic                in_rdy,
  input  bcr_pkg::in_item_t   in_item,
  output logic                mid_push,
  input  logic                mid_full,
  output bcr_pkg::mid_item_t  mid_item
);

  logic               f0_vld_r, f0_vld_nxt;
  logic               f0_en;
  bcr_pkg::in_item_t  f0_item_r;
  logic signed [31:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic signed [32:0] lo_x_r, hi_x_r, lo_y_r, hi_y_r;

  logic signed [31:0] min_x, max_x, min_y, max_y;
  logic signed [32:0] rad_s;

  // box extents from the two corners
  always_comb begin
    if (cfg.corner_a_x < cfg.corner_b_x) begin
      min_x = cfg.corner_a_x;
      max_x = cfg.corner_b_x;
    end else begin
      min_x = cfg.corner_b_x;
      max_x = cfg.corner_a_x;
    end
    if (cfg.corner_a_y < cfg.corner_b_y) begin
      min_y = cfg.corner_a_y;
      max_y = cfg.corner_b_y;
    end else begin
      min_y = cfg.corner_b_y;
      max_y = cfg.corner_a_y;
    end
  end

  assign rad_s  = $signed({2'b00, in_item.radius});
  assign f0_en  = !f0_vld_r || !mid_full;
  assign in_rdy = f0_en;

  // stage 0: capture item, extents and disc bounds
  assign f0_vld_nxt = f0_en ? in_vld : f0_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_vld_r <= 1'b0;
    end else begin
      f0_vld_r <= f0_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (f0_en && in_vld) begin
      f0_item_r <= in_item;
      min_x_r   <= min_x;
      max_x_r   <= max_x;
      min_y_r   <= min_y;
      max_y_r   <= max_y;
      lo_x_r    <= 33'(in_item.pos_x) - rad_s;
      hi_x_r    <= 33'(in_item.pos_x) + rad_s;
      lo_y_r    <= 33'(in_item.pos_y) - rad_s;
      hi_y_r    <= 33'(in_item.pos_y) + rad_s;
    end
  end

  // stage 1: inside test, nearest side, reflection
  logic               in_box;
  logic signed [33:0] gap_l, gap_t, gap_r, gap_b, best;
  bcr_pkg::side_t     side;
  logic signed [32:0] vx, vy;

  always_comb begin
    in_box = (lo_x_r >= 33'(min_x_r)) && (hi_x_r <= 33'(max_x_r)) &&
             (lo_y_r >= 33'(min_y_r)) && (hi_y_r <= 33'(max_y_r));
    gap_l = 34'(f0_item_r.pos_x) - 34'(min_x_r);
    gap_t = 34'(max_y_r) - 34'(f0_item_r.pos_y);
    gap_r = 34'(max_x_r) - 34'(f0_item_r.pos_x);
    gap_b = 34'(f0_item_r.pos_y) - 34'(min_y_r);
    best  = gap_l;
    side  = bcr_pkg::SIDE_LEFT;
    if (gap_t < best) begin
      best = gap_t;
      side = bcr_pkg::SIDE_TOP;
    end
    if (gap_r < best) begin
      best = gap_r;
      side = bcr_pkg::SIDE_RIGHT;
    end
    if (gap_b < best) begin
      side = bcr_pkg::SIDE_BOTTOM;
    end
    vx = 33'(f0_item_r.vel_x);
    vy = 33'(f0_item_r.vel_y);
    if (in_box) begin
      case (side)
        bcr_pkg::SIDE_LEFT, bcr_pkg::SIDE_RIGHT: vx = -vx;
        default:                                 vy = -vy;
      endcase
    end
  end

  assign mid_push       = f0_vld_r;
  assign mid_item.hit   = in_box;
  assign mid_item.pos_x = f0_item_r.pos_x;
  assign mid_item.pos_y = f0_item_r.pos_y;
  assign mid_item.vel_x = vx;
  assign mid_item.vel_y = vy;

endmodule

// ===== rtl/bcr_back.sv =====
`timescale 1ns / 1ps
module bcr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bcr_pkg::cfg_t       cfg,
  input  logic                mid_empty,
  output logic                mid_pop,
  input  bcr_pkg::mid_item_t  mid_item,
  output logic                res_push,
  input  logic                res_full,
  output bcr_pkg::out_item_t  res_item
);

  // stage enables, each stage moves when the next can take it
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic s1_en, s2_en, s3_en, s4_en;

  assign s4_en   = !s4_vld_r || !res_full;
  assign s3_en   = !s3_vld_r || s4_en;
  assign s2_en   = !s2_vld_r || s3_en;
  assign s1_en   = !s1_vld_r || s2_en;
  assign mid_pop = s1_en && !mid_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (s1_en) s1_vld_r <= !mid_empty;
      if (s2_en) s2_vld_r <= s1_vld_r;
      if (s3_en) s3_vld_r <= s2_vld_r;
      if (s4_en) s4_vld_r <= s3_vld_r;
    end
  end

  // stage 1: velocity times restitution (1.0 on a miss)
  logic               s1_hit_r;
  logic signed [31:0] s1_px_r, s1_py_r;
  logic signed [51:0] s1_mx_r, s1_my_r;
  logic signed [18:0] rest_s;

  assign rest_s = $signed({1'b0, mid_item.hit ? cfg.restitution
                                              : bcr_pkg::RESTITUTION_ONE});

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      s1_hit_r <= mid_item.hit;
      s1_px_r  <= mid_item.pos_x;
      s1_py_r  <= mid_item.pos_y;
      s1_mx_r  <= mid_item.vel_x * rest_s;
      s1_my_r  <= mid_item.vel_y * rest_s;
    end
  end

  // stage 2: round and saturate new velocity
  logic               s2_hit_r;
  logic signed [31:0] s2_px_r, s2_py_r, s2_vx_r, s2_vy_r;
  logic signed [51:0] rx, ry;

  assign rx = s1_mx_r + 52'sd32768;
  assign ry = s1_my_r + 52'sd32768;

  always_ff @(posedge clk) begin
    if (s2_en && s1_vld_r) begin
      s2_hit_r <= s1_hit_r;
      s2_px_r  <= s1_px_r;
      s2_py_r  <= s1_py_r;
      s2_vx_r  <= bcr_pkg::sat32(49'($signed(rx[51:16])));
      s2_vy_r  <= bcr_pkg::sat32(49'($signed(ry[51:16])));
    end
  end

  // stage 3: new velocity times step time (zero on a miss)
  logic               s3_hit_r;
  logic signed [31:0] s3_px_r, s3_py_r, s3_vx_r, s3_vy_r;
  logic signed [64:0] s3_mx_r, s3_my_r;
  logic signed [32:0] dt_s;

  assign dt_s = $signed({1'b0, s2_hit_r ? cfg.step_time : 32'd0});

  always_ff @(posedge clk) begin
    if (s3_en && s2_vld_r) begin
      s3_hit_r <= s2_hit_r;
      s3_px_r  <= s2_px_r;
      s3_py_r  <= s2_py_r;
      s3_vx_r  <= s2_vx_r;
      s3_vy_r  <= s2_vy_r;
      s3_mx_r  <= s2_vx_r * dt_s;
      s3_my_r  <= s2_vy_r * dt_s;
    end
  end

  // stage 4: half step displacement, add to position, saturate
  logic signed [64:0] dx, dy;
  logic signed [48:0] sum_x, sum_y;

  assign dx    = s3_mx_r + 65'sd65536;
  assign dy    = s3_my_r + 65'sd65536;
  assign sum_x = 49'($signed(dx[64:17])) + 49'(s3_px_r);
  assign sum_y = 49'($signed(dy[64:17])) + 49'(s3_py_r);

  always_ff @(posedge clk) begin
    if (s4_en && s3_vld_r) begin
      res_item.hit       <= s3_hit_r;
      res_item.new_vel_x <= s3_vx_r;
      res_item.new_vel_y <= s3_vy_r;
      res_item.new_pos_x <= bcr_pkg::sat32(sum_x);
      res_item.new_pos_y <= bcr_pkg::sat32(sum_y);
    end
  end

  assign res_push = s4_vld_r;

`ifndef NO_ASSERTIONS
  a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_vld_r && res_full) |=> (s4_vld_r && $stable(res_item)))
    else $error("last stage lost its result while stalled");
`endif

endmodule

// ===== rtl/box_collider_reflect_2d_top.sv =====
`timescale 1ns / 1ps
// Path: an accepted push passes one front stage, the classify queue, four back
//   stages and the result queue before the result shows (empty low).
// Throughput: one particle per cycle while the consumer keeps popping results.
// Reset: rst_n synchronous active low; clears queues, pipeline valids and the
//   configuration registers (corners 0, restitution 1.0, step time 0).
module box_collider_reflect_2d_top #(
  parameter int unsigned MID_DEPTH = 4,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              push,
  output logic                              full,
  input  bcr_pkg::in_item_t                 in_data,
  // result channel
  output logic                              empty,
  input  logic                              pop,
  output bcr_pkg::out_item_t                out_data,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bcr_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  bcr_pkg::cfg_t cfg_r;
  logic [2:0]    reg_idx;
  logic          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.corner_a_x  <= '0;
      cfg_r.corner_a_y  <= '0;
      cfg_r.corner_b_x  <= '0;
      cfg_r.corner_b_y  <= '0;
      cfg_r.restitution <= bcr_pkg::RESTITUTION_RST;
      cfg_r.step_time   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        bcr_pkg::REG_CORNER_A_X:  cfg_r.corner_a_x  <= pwdata;
        bcr_pkg::REG_CORNER_A_Y:  cfg_r.corner_a_y  <= pwdata;
        bcr_pkg::REG_CORNER_B_X:  cfg_r.corner_b_x  <= pwdata;
        bcr_pkg::REG_CORNER_B_Y:  cfg_r.corner_b_y  <= pwdata;
        bcr_pkg::REG_RESTITUTION: cfg_r.restitution <= pwdata[17:0];
        bcr_pkg::REG_STEP_TIME:   cfg_r.step_time   <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      bcr_pkg::REG_CORNER_A_X:  prdata = cfg_r.corner_a_x;
      bcr_pkg::REG_CORNER_A_Y:  prdata = cfg_r.corner_a_y;
      bcr_pkg::REG_CORNER_B_X:  prdata = cfg_r.corner_b_x;
      bcr_pkg::REG_CORNER_B_Y:  prdata = cfg_r.corner_b_y;
      bcr_pkg::REG_RESTITUTION: prdata = {14'd0, cfg_r.restitution};
      bcr_pkg::REG_STEP_TIME:   prdata = cfg_r.step_time;
      default:                  prdata = '0;
    endcase
  end

  // front: classify
  logic               in_rdy;
  logic               mid_push, mid_full, mid_pop, mid_empty;
  bcr_pkg::mid_item_t mid_wr, mid_rd;

  assign full = !in_rdy;

  bcr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_vld   (push),
    .in_rdy   (in_rdy),
    .in_item  (in_data),
    .mid_push (mid_push),
    .mid_full (mid_full),
    .mid_item (mid_wr)
  );

  bcr_fifo #(
    .WIDTH ($bits(bcr_pkg::mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (mid_push),
    .wr_data (mid_wr),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  // back: scale and advance
  logic               res_push, res_full;
  bcr_pkg::out_item_t res_item;

  bcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .mid_item  (mid_rd),
    .res_push  (res_push),
    .res_full  (res_full),
    .res_item  (res_item)
  );

  bcr_fifo #(
    .WIDTH ($bits(bcr_pkg::out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_item),
    .full    (res_full),
    .pop     (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam longint Q         = 65536;     // 1.0 in Q16.16
  localparam int     LIMIT     = 200000;    // cycles before giving up
  localparam int     HOLD_LEN  = 300;       // long consumer stall

  // DUT signals
  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               push    = 1'b0;
  logic               full;
  bcr_pkg::in_item_t  in_data = '0;
  logic               empty;
  logic               pop     = 1'b0;
  bcr_pkg::out_item_t out_data;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [bcr_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow copy of the configuration registers
  logic signed [31:0] box_ax = '0;
  logic signed [31:0] box_ay = '0;
  logic signed [31:0] box_bx = '0;
  logic signed [31:0] box_by = '0;
  logic        [17:0] restitution = 18'd65536;
  logic        [31:0] step_time   = '0;

  bcr_pkg::in_item_t  pending_particles[$];
  bcr_pkg::out_item_t predicted_results[$];

  int   cycle_count    = 0;
  int   mismatch_count = 0;
  int   send_gap       = 0;
  int   recv_gap       = 0;
  int   hold_left      = 0;
  logic hold_kick      = 1'b0;
  logic hold_seen      = 1'b0;
  logic calm           = 1'b0;

  box_collider_reflect_2d_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Clock
  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Saturate to a 32-bit signed word
  function automatic logic signed [31:0] clamp_word(input logic signed [79:0] v);
    logic signed [31:0] res;
    if (v > 80'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -80'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // Expected response of the collider for one particle
  function automatic bcr_pkg::out_item_t reflect_particle(input bcr_pkg::in_item_t p);
    logic signed [79:0] px, py, vx, vy, r;
    logic signed [79:0] ax, ay, bx, by;
    logic signed [79:0] minx, maxx, miny, maxy, gap_best;
    logic signed [79:0] rest_w, dt_w, nvx_w, nvy_w;
    logic signed [31:0] nvx, nvy;
    logic               in_box;
    bcr_pkg::side_t     wall;
    bcr_pkg::out_item_t res;
    px = $signed(p.pos_x);
    py = $signed(p.pos_y);
    vx = $signed(p.vel_x);
    vy = $signed(p.vel_y);
    r  = {49'b0, p.radius};
    ax = $signed(box_ax);
    ay = $signed(box_ay);
    bx = $signed(box_bx);
    by = $signed(box_by);
    minx = (ax < bx) ? ax : bx;
    maxx = (ax < bx) ? bx : ax;
    miny = (ay < by) ? ay : by;
    maxy = (ay < by) ? by : ay;
    in_box = (px - r >= minx) && (px + r <= maxx) &&
             (py - r >= miny) && (py + r <= maxy);
    res.new_pos_x = p.pos_x;
    res.new_pos_y = p.pos_y;
    res.new_vel_x = p.vel_x;
    res.new_vel_y = p.vel_y;
    res.hit       = 1'b0;
    if (in_box) begin
      // nearest wall, ties resolved left, top, right, bottom
      wall = bcr_pkg::SIDE_LEFT;
      gap_best = px - minx;
      if (maxy - py < gap_best) begin
        gap_best = maxy - py;
        wall = bcr_pkg::SIDE_TOP;
      end
      if (maxx - px < gap_best) begin
        gap_best = maxx - px;
        wall = bcr_pkg::SIDE_RIGHT;
      end
      if (py - miny < gap_best) begin
        gap_best = py - miny;
        wall = bcr_pkg::SIDE_BOTTOM;
      end
      if (wall == bcr_pkg::SIDE_LEFT || wall == bcr_pkg::SIDE_RIGHT) begin
        vx = -vx;
      end else begin
        vy = -vy;
      end
      // scale by restitution, round half up
      rest_w = {62'b0, restitution};
      nvx = clamp_word((vx * rest_w + 80'sd32768) >>> 16);
      nvy = clamp_word((vy * rest_w + 80'sd32768) >>> 16);
      // half-step position update
      dt_w  = {48'b0, step_time};
      nvx_w = nvx;
      nvy_w = nvy;
      res.new_pos_x = clamp_word(px + ((nvx_w * dt_w + 80'sd65536) >>> 17));
      res.new_pos_y = clamp_word(py + ((nvy_w * dt_w + 80'sd65536) >>> 17));
      res.new_vel_x = nvx;
      res.new_vel_y = nvy;
      res.hit       = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h", what, got, want));
    end
  endtask

  // Driver: offers the oldest pending particle, with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        predicted_results.push_back(reflect_particle(pending_particles.pop_front()));
      end
      if (send_gap == 0 && !calm && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 10);
      end
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (pending_particles.size() > 0) begin
        push    <= 1'b1;
        in_data <= pending_particles[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: accepts results and checks them in order
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          check_field("new_pos_x", out_data.new_pos_x, predicted_results[0].new_pos_x);
          check_field("new_pos_y", out_data.new_pos_y, predicted_results[0].new_pos_y);
          check_field("new_vel_x", out_data.new_vel_x, predicted_results[0].new_vel_x);
          check_field("new_vel_y", out_data.new_vel_y, predicted_results[0].new_vel_y);
          check_field("hit", {31'b0, out_data.hit}, {31'b0, predicted_results[0].hit});
          void'(predicted_results.pop_front());
        end
      end
      if (hold_kick != hold_seen) begin
        hold_seen = hold_kick;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 9);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // APB write: setup then access phase
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      bcr_pkg::REG_CORNER_A_X:  box_ax = val;
      bcr_pkg::REG_CORNER_A_Y:  box_ay = val;
      bcr_pkg::REG_CORNER_B_X:  box_bx = val;
      bcr_pkg::REG_CORNER_B_Y:  box_by = val;
      bcr_pkg::REG_RESTITUTION: restitution = val[17:0];
      bcr_pkg::REG_STEP_TIME:   step_time = val;
      default: ;
    endcase
  endtask

  // Wait until every particle is sent and every result checked
  task automatic drain();
    while (pending_particles.size() != 0 || predicted_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic bcr_pkg::in_item_t particle(input longint px, input longint py,
                                                 input longint vx, input longint vy,
                                                 input longint r);
    bcr_pkg::in_item_t p;
    p.pos_x  = px[31:0];
    p.pos_y  = py[31:0];
    p.vel_x  = vx[31:0];
    p.vel_y  = vy[31:0];
    p.radius = r[30:0];
    return p;
  endfunction

  function automatic longint rand_upto(input longint n);
    longint unsigned u;
    if (n <= 0) begin
      return 0;
    end
    u = {$urandom, $urandom};
    return longint'(u % longint'(n + 1));
  endfunction

  function automatic longint rand_vel();
    longint v;
    if ($urandom_range(0, 1) == 0) begin
      v = longint'($signed($urandom));
    end else begin
      v = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
    end
    return v;
  endfunction

  // Particle placed inside the current box, sometimes touching or just past a wall
  function automatic bcr_pkg::in_item_t aimed_particle();
    longint minx, maxx, miny, maxy, w, h, rmax, r, px, py;
    minx = (box_ax < box_bx) ? box_ax : box_bx;
    maxx = (box_ax < box_bx) ? box_bx : box_ax;
    miny = (box_ay < box_by) ? box_ay : box_by;
    maxy = (box_ay < box_by) ? box_by : box_ay;
    w = maxx - minx;
    h = maxy - miny;
    rmax = ((w < h) ? w : h) / 2;
    if (rmax > 64'sd2147483647) begin
      rmax = 64'sd2147483647;
    end
    r  = rand_upto(rmax >> $urandom_range(0, 16));
    px = minx + r + rand_upto(w - 2 * r);
    py = miny + r + rand_upto(h - 2 * r);
    case ($urandom_range(0, 11))
      0: px = minx + r;
      1: px = maxx - r;
      2: py = miny + r;
      3: py = maxy - r;
      4: px = minx + r - 1;
      5: py = maxy - r + 1;
      default: ;
    endcase
    return particle(px, py, rand_vel(), rand_vel(), r);
  endfunction

  function automatic bcr_pkg::in_item_t noise_particle();
    bcr_pkg::in_item_t p;
    p.pos_x  = $urandom;
    p.pos_y  = $urandom;
    p.vel_x  = $urandom;
    p.vel_y  = $urandom;
    p.radius = ($urandom_range(0, 1) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
    return p;
  endfunction

  // New random box, restitution and time step
  task automatic random_setup();
    longint cx, cy, hw, hh;
    case ($urandom_range(0, 3))
      0: begin
        write_reg(bcr_pkg::REG_CORNER_A_X, $urandom);
        write_reg(bcr_pkg::REG_CORNER_A_Y, $urandom);
        write_reg(bcr_pkg::REG_CORNER_B_X, $urandom);
        write_reg(bcr_pkg::REG_CORNER_B_Y, $urandom);
      end
      1: begin
        // compact box, sometimes of zero width or height
        cx = longint'($signed($urandom)) >>> 2;
        cy = longint'($signed($urandom)) >>> 2;
        hw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1 << 22);
        hh = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1 << 22);
        if ($urandom_range(0, 1) == 0) begin
          hw = -hw;
        end
        write_reg(bcr_pkg::REG_CORNER_A_X, 32'(cx - hw));
        write_reg(bcr_pkg::REG_CORNER_A_Y, 32'(cy + hh));
        write_reg(bcr_pkg::REG_CORNER_B_X, 32'(cx + hw));
        write_reg(bcr_pkg::REG_CORNER_B_Y, 32'(cy - hh));
      end
      2: begin
        write_reg(bcr_pkg::REG_CORNER_A_X, 32'h7FFFFFFF);
        write_reg(bcr_pkg::REG_CORNER_A_Y, 32'h80000000);
        write_reg(bcr_pkg::REG_CORNER_B_X, 32'h80000000);
        write_reg(bcr_pkg::REG_CORNER_B_Y, 32'h7FFFFFFF);
      end
      default: begin
        write_reg(bcr_pkg::REG_CORNER_A_X, 32'($urandom_range(0, 1 << 25)) - (1 << 24));
        write_reg(bcr_pkg::REG_CORNER_A_Y, 32'($urandom_range(0, 1 << 25)) - (1 << 24));
        write_reg(bcr_pkg::REG_CORNER_B_X, 32'($urandom_range(0, 1 << 25)) - (1 << 24));
        write_reg(bcr_pkg::REG_CORNER_B_Y, 32'($urandom_range(0, 1 << 25)) - (1 << 24));
      end
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(bcr_pkg::REG_RESTITUTION, 32'd0);
      1: write_reg(bcr_pkg::REG_RESTITUTION, 32'h3FFFF);
      2: write_reg(bcr_pkg::REG_RESTITUTION, 32'd65536);
      default: write_reg(bcr_pkg::REG_RESTITUTION, $urandom);
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(bcr_pkg::REG_STEP_TIME, 32'd0);
      1: write_reg(bcr_pkg::REG_STEP_TIME, 32'hFFFFFFFF);
      2: write_reg(bcr_pkg::REG_STEP_TIME, $urandom_range(0, 1 << 18));
      default: write_reg(bcr_pkg::REG_STEP_TIME, $urandom);
    endcase
  endtask

  // Stimulus sequence
  initial begin : stimulus
    int ph, k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset box is a single point at the origin
    pending_particles.push_back(particle(0, 0, Q, -Q, 0));
    pending_particles.push_back(particle(Q, 0, Q, Q, 0));
    drain();

    // box x in [-100, 100], y in [-50, 50], x corners given swapped
    write_reg(bcr_pkg::REG_CORNER_A_X, 32'(100 * Q));
    write_reg(bcr_pkg::REG_CORNER_A_Y, 32'(-50 * Q));
    write_reg(bcr_pkg::REG_CORNER_B_X, 32'(-100 * Q));
    write_reg(bcr_pkg::REG_CORNER_B_Y, 32'(50 * Q));
    write_reg(bcr_pkg::REG_RESTITUTION, 32'd49152);
    write_reg(bcr_pkg::REG_STEP_TIME, 32'(Q));
    pending_particles.push_back(particle(0, 0, Q, 2 * Q, 0));                 // top/bottom tie
    pending_particles.push_back(particle(-90 * Q, 0, -3 * Q, Q, 5 * Q));      // left
    pending_particles.push_back(particle(90 * Q, 0, 3 * Q, Q, 5 * Q));        // right
    pending_particles.push_back(particle(0, 40 * Q, Q, 32'h7FFFFFFF, 5 * Q)); // top
    pending_particles.push_back(particle(0, -40 * Q, Q, -4 * Q, 5 * Q));      // bottom
    pending_particles.push_back(particle(-95 * Q, 0, -Q, 0, 5 * Q));          // touching left
    pending_particles.push_back(particle(-95 * Q, 0, -Q, 0, 5 * Q + 1));      // just outside
    pending_particles.push_back(particle(-90 * Q, 40 * Q, 32'h80000000, Q, 0)); // left/top tie
    pending_particles.push_back(particle(90 * Q, -40 * Q, Q, Q, 0));          // right/bottom tie
    pending_particles.push_back(particle(90 * Q, 40 * Q, Q, Q, 0));           // top/right tie
    pending_particles.push_back(particle(0, 0, Q, Q, 32'h7FFFFFFF));          // huge radius
    pending_particles.push_back(particle(32'h7FFFFFFF, 32'h80000000, Q, Q, 0)); // far outside
    drain();

    // full-range box, maximal restitution and time step
    write_reg(bcr_pkg::REG_CORNER_A_X, 32'h80000000);
    write_reg(bcr_pkg::REG_CORNER_A_Y, 32'h80000000);
    write_reg(bcr_pkg::REG_CORNER_B_X, 32'h7FFFFFFF);
    write_reg(bcr_pkg::REG_CORNER_B_Y, 32'h7FFFFFFF);
    write_reg(bcr_pkg::REG_RESTITUTION, 32'h3FFFF);
    write_reg(bcr_pkg::REG_STEP_TIME, 32'hFFFFFFFF);
    pending_particles.push_back(particle(32'h7FFFFFFF, 0, 32'h7FFFFFFF, -1, 0));
    pending_particles.push_back(particle(32'h80000000, 5, 32'h80000000, 32'h7FFFFFFF, 0));
    pending_particles.push_back(particle(0, 32'h7FFFFFFF, 7, 32'h80000000, 0));
    pending_particles.push_back(particle(0, 32'h80000000, -7, 32'h7FFFFFFF, 0));
    pending_particles.push_back(particle(0, 0, 32'h80000000, 32'h80000000, 32'h7FFFFFFF));
    pending_particles.push_back(particle(-1, -1, 32'h7FFFFFFF, 1, 32'h7FFFFFFF));
    pending_particles.push_back(particle(0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    drain();

    // random phases; long consumer stall in one, no idling in the last
    for (ph = 0; ph < 8; ph++) begin
      drain();
      random_setup();
      if (ph == 2) begin
        hold_kick = ~hold_kick;
      end
      if (ph == 7) begin
        calm = 1'b1;
      end
      for (k = 0; k < 66; k++) begin
        if ($urandom_range(0, 9) < 7) begin
          pending_particles.push_back(aimed_particle());
        end else begin
          pending_particles.push_back(noise_particle());
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
